// ===== hw/rtl/escd_pkg.sv =====
// Shared constants, types and the fixed sequence table of the escape-sequence key decoder.
`timescale 1ns / 1ps

package escd_pkg;

  localparam int MAX_SEQ_BYTES = 7;
  localparam int CNT_W         = $clog2(MAX_SEQ_BYTES + 1);
  localparam int IDX_W         = $clog2(MAX_SEQ_BYTES);

  localparam int NUM_FIXED   = 4;
  localparam int NUM_ALT     = 4;
  localparam int NUM_ENTRIES = NUM_FIXED + NUM_ALT;
  localparam int FIXED_LEN   = 3;

  localparam logic [7:0]  ESC_BYTE      = 8'd27;
  localparam logic [15:0] TIMEOUT_RESET = 16'd900;

  // Fixed arrow sequences: up, down, left, right.
  localparam logic [7:0] FIXED_SEQ [NUM_FIXED][FIXED_LEN] = '{
    '{8'd27, 8'd91, 8'd65},
    '{8'd27, 8'd91, 8'd66},
    '{8'd27, 8'd91, 8'd68},
    '{8'd27, 8'd91, 8'd67}
  };

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_UP_ALT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_DOWN_ALT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LEFT_ALT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_RIGHT_ALT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT       = 3'd4;

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } escd_cfg_wr_t;

  // One queued job: count bytes to emit, oldest in bytes[0].
  typedef struct packed {
    logic                          is_key;
    logic [CNT_W-1:0]              count;
    logic [MAX_SEQ_BYTES-1:0][7:0] bytes;
  } escd_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } escd_q_stat_t;

endpackage

// ===== hw/rtl/escd_in_if.sv =====
// Input channel: received bytes and time ticks.
`timescale 1ns / 1ps

interface escd_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink (input valid, input func, input rx_byte, output ready);
endinterface

// ===== hw/rtl/escd_out_if.sv =====
// Output channel: decoded keys and raw bytes.
`timescale 1ns / 1ps

interface escd_out_if;
  logic       valid;
  logic       ready;
  logic       is_key;
  logic [7:0] key_value;
  logic       last;

  modport source (output valid, output is_key, output key_value, output last, input ready);
  modport sink (input valid, input is_key, input key_value, input last, output ready);
endinterface

// ===== hw/rtl/escd_front.sv =====
// Front end: buffers escape bytes, matches sequences, queues output jobs.
`timescale 1ns / 1ps

module escd_front (
  input  logic                   clk,
  input  logic                   rst,
  escd_in_if.sink                in_ch,
  input  escd_pkg::escd_cfg_wr_t cfg,
  input  escd_pkg::escd_q_stat_t q_stat,
  output logic                   push,
  output escd_pkg::escd_cmd_t    push_cmd
);
  import escd_pkg::*;

  logic [CFG_DATA_W-1:0]         alt_seq [NUM_ALT];
  logic [15:0]                   timeout_ticks;
  logic [MAX_SEQ_BYTES-1:0][7:0] pend, pend_app, pend_next;
  logic [CNT_W-1:0]              count, cnt_app, count_next;
  logic [15:0]                   ticks, ticks_next;
  logic                          fire, room, hit, partial;
  logic [1:0]                    code;
  logic [7:0]                    ent_len  [NUM_ENTRIES];
  logic [7:0]                    ent_byte [NUM_ENTRIES][MAX_SEQ_BYTES];
  logic [NUM_ENTRIES-1:0]        ent_ok, ent_eq, ent_full, ent_part;

  assign in_ch.ready = !q_stat.full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign room        = count < CNT_W'(MAX_SEQ_BYTES);

  // Buffer with the incoming byte appended.
  always_comb begin
    pend_app = pend;
    cnt_app  = count + 1'b1;
    if (room) begin
      pend_app[count[IDX_W-1:0]] = in_ch.rx_byte;
    end
  end

  // Table of the eight entries.
  always_comb begin
    for (int e = 0; e < NUM_FIXED; e++) begin
      ent_len[e] = 8'(FIXED_LEN);
      ent_ok[e]  = 1'b1;
      for (int k = 0; k < MAX_SEQ_BYTES; k++) begin
        ent_byte[e][k] = 8'h00;
        if (k < FIXED_LEN) begin
          ent_byte[e][k] = FIXED_SEQ[e][k];
        end
      end
    end
    for (int a = 0; a < NUM_ALT; a++) begin
      ent_len[NUM_FIXED+a] = alt_seq[a][7:0];
      ent_ok[NUM_FIXED+a]  = (alt_seq[a][7:0] != 8'd0) &&
                             (alt_seq[a][7:0] <= 8'(MAX_SEQ_BYTES));
      for (int k = 0; k < MAX_SEQ_BYTES; k++) begin
        ent_byte[NUM_FIXED+a][k] = alt_seq[a][8*k+8 +: 8];
      end
    end
  end

  // Compare every entry against the appended buffer in parallel.
  always_comb begin
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      ent_eq[e] = 1'b1;
      for (int k = 0; k < MAX_SEQ_BYTES; k++) begin
        if ((CNT_W'(k) < cnt_app) && (pend_app[k] != ent_byte[e][k])) begin
          ent_eq[e] = 1'b0;
        end
      end
      ent_full[e] = ent_ok[e] && ent_eq[e] && (8'(cnt_app) == ent_len[e]);
      ent_part[e] = ent_ok[e] && ent_eq[e] && (8'(cnt_app) < ent_len[e]);
    end
    hit  = 1'b0;
    code = 2'd0;
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      if (ent_full[e] && !hit) begin
        hit  = 1'b1;
        code = 2'(e);
      end
    end
    partial = |ent_part;
  end

  always_comb begin
    push           = 1'b0;
    push_cmd.is_key = 1'b0;
    push_cmd.count = count;
    push_cmd.bytes = pend;
    count_next     = count;
    ticks_next     = ticks;
    pend_next      = pend;
    if (fire) begin
      if (in_ch.func == FUNC_TICK) begin
        if (count != '0) begin
          if (ticks <= 16'd1) begin
            // Timed out: replay what is buffered.
            push       = 1'b1;
            count_next = '0;
            ticks_next = '0;
          end else begin
            ticks_next = ticks - 16'd1;
          end
        end
      end else if ((count == '0) && (in_ch.rx_byte != ESC_BYTE)) begin
        push              = 1'b1;
        push_cmd.count    = CNT_W'(1);
        push_cmd.bytes    = '0;
        push_cmd.bytes[0] = in_ch.rx_byte;
      end else if (!room) begin
        // Buffer full: replay it and drop the new byte.
        push       = 1'b1;
        count_next = '0;
        ticks_next = '0;
      end else begin
        pend_next = pend_app;
        if (hit) begin
          push              = 1'b1;
          push_cmd.is_key   = 1'b1;
          push_cmd.count    = CNT_W'(1);
          push_cmd.bytes    = '0;
          push_cmd.bytes[0] = 8'(code);
          count_next        = '0;
          ticks_next        = '0;
        end else if (partial) begin
          count_next = cnt_app;
          if (cnt_app == CNT_W'(1)) begin
            ticks_next = timeout_ticks;
          end
        end else begin
          push           = 1'b1;
          push_cmd.count = cnt_app;
          push_cmd.bytes = pend_app;
          count_next     = '0;
          ticks_next     = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      ticks         <= '0;
      timeout_ticks <= TIMEOUT_RESET;
      for (int a = 0; a < NUM_ALT; a++) begin
        alt_seq[a] <= '0;
      end
    end else begin
      count <= count_next;
      ticks <= ticks_next;
      if (cfg.we) begin
        case (cfg.index)
          CFG_SEQ_UP_ALT:    alt_seq[0]    <= cfg.data;
          CFG_SEQ_DOWN_ALT:  alt_seq[1]    <= cfg.data;
          CFG_SEQ_LEFT_ALT:  alt_seq[2]    <= cfg.data;
          CFG_SEQ_RIGHT_ALT: alt_seq[3]    <= cfg.data;
          CFG_TIMEOUT:       timeout_ticks <= cfg.data[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
  end

endmodule

// ===== hw/rtl/escd_queue.sv =====
// Short job queue between the front and back ends.
`timescale 1ns / 1ps

module escd_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  escd_pkg::escd_cmd_t    push_cmd,
  input  logic                   pop,
  output escd_pkg::escd_cmd_t    pop_cmd,
  output escd_pkg::escd_q_stat_t stat
);
  import escd_pkg::*;

  escd_cmd_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QFILL_W-1:0]  fill;

  assign pop_cmd    = mem[rd_ptr];
  assign stat.full  = fill == QFILL_W'(QUEUE_DEPTH);
  assign stat.empty = fill == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== hw/rtl/escd_back.sv =====
// Back end: plays queued jobs out one result item per cycle while the output is ready.
`timescale 1ns / 1ps

module escd_back (
  input  logic                   clk,
  input  logic                   rst,
  input  escd_pkg::escd_q_stat_t q_stat,
  input  escd_pkg::escd_cmd_t    pop_cmd,
  output logic                   pop,
  escd_out_if.source             out_ch
);
  import escd_pkg::*;

  escd_cmd_t         cur;
  logic              busy;
  logic [IDX_W-1:0]  idx;
  logic              fin;

  assign out_ch.valid     = busy;
  assign out_ch.is_key    = cur.is_key;
  assign out_ch.key_value = cur.bytes[idx];
  assign out_ch.last      = (CNT_W'(idx) + 1'b1) == cur.count;

  assign fin = busy && out_ch.ready && out_ch.last;
  assign pop = !q_stat.empty && (!busy || fin);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (fin) begin
      busy <= 1'b0;
    end else if (busy && out_ch.ready) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_cmd;
    end
  end

endmodule

// ===== hw/rtl/escape_sequence_key_decoder.sv =====
// Each job is written to the queue at the accept edge and loaded into the back end once the
// back end is free; its first result item is then presented.
// Throughput: an input item is taken every cycle while the two-entry job queue has room;
// the back end emits one result per ready cycle, so a replay of n bytes yields n items.
// Sequence matching of all eight entries is done in the single accept cycle.
// Reset (synchronous): empties buffer, timer and queue; alternates read 0, timeout 900.
`timescale 1ns / 1ps

module escape_sequence_key_decoder (
  input  logic                            clk,
  input  logic                            rst,
  escd_in_if.sink                         in_ch,
  escd_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [escd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [escd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import escd_pkg::*;

  escd_cfg_wr_t cfg;
  escd_q_stat_t q_stat;
  escd_cmd_t    push_cmd, pop_cmd;
  logic         push, pop;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  escd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .cfg      (cfg),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  escd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .stat     (q_stat)
  );

  escd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_stat  (q_stat),
    .pop_cmd (pop_cmd),
    .pop     (pop),
    .out_ch  (out_ch)
  );

  // A decoded key is always a single item with a valid code.
  a_key_single: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.is_key) |-> (out_ch.last && (out_ch.key_value < 8'd4)))
    else $error("key item not single or code out of range");

  // Finishing a job with nothing queued leaves the output idle.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && out_ch.last && q_stat.empty) |=> !out_ch.valid)
    else $error("output valid without a queued job");

  // Output only starts from a job that sat in the queue.
  a_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(!q_stat.empty))
    else $error("output started with empty queue");

endmodule

// ===== bench/escape_sequence_key_decoder_tb.sv =====
// Self-checking testbench for the escape-sequence key decoder.
`timescale 1ns / 1ps

module escape_sequence_key_decoder_tb;
  import escd_pkg::*;

  localparam logic [7:0] CSI_BRACKET = 8'h5B;
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD    = 80;
  localparam int WATCHDOG_NS  = 3_000_000;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } key_input_t;

  typedef struct packed {
    logic       is_key;
    logic [7:0] key_value;
    logic       last;
  } key_result_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  escd_in_if  in_ch ();
  escd_out_if out_ch ();

  escape_sequence_key_decoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Predictor state and its copy of the registers.
  logic [63:0] alt_setting [NUM_ALT] = '{default: '0};
  logic [15:0] timeout_setting = TIMEOUT_RESET;
  logic [MAX_SEQ_BYTES-1:0][7:0] held_bytes = '0;
  int          held_count = 0;
  logic [15:0] wait_ticks = '0;

  key_input_t  pending_items [$];
  key_result_t expected_keys [$];

  int   fail_count   = 0;
  int   src_idle_pct = 9;
  int   snk_idle_pct = 9;
  int   stall_asked  = 0;
  int   stall_served = 0;
  int   hold_left    = 0;
  logic in_taken     = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // Entry e in match order; returns 0 when the entry is absent.
  function automatic bit entry_seq(input int e, output int len,
                                   output logic [MAX_SEQ_BYTES-1:0][7:0] seq);
    logic [63:0] r;
    seq = '0;
    len = 0;
    if (e < NUM_FIXED) begin
      len = FIXED_LEN;
      for (int k = 0; k < FIXED_LEN; k++) seq[k] = FIXED_SEQ[e][k];
      return 1'b1;
    end
    r = alt_setting[e - NUM_FIXED];
    if (r[7:0] == 0 || r[7:0] > MAX_SEQ_BYTES) return 1'b0;
    len = r[7:0];
    for (int k = 0; k < len; k++) seq[k] = r[8*(k+1) +: 8];
    return 1'b1;
  endfunction

  function automatic void note_result(logic is_key, logic [7:0] value, logic last);
    expected_keys.push_back('{is_key, value, last});
  endfunction

  function automatic void flush_held();
    for (int k = 0; k < held_count; k++)
      note_result(1'b0, held_bytes[k], k == held_count - 1);
    held_count = 0;
    wait_ticks = '0;
  endfunction

  function automatic void predict_keys(logic func, logic [7:0] b);
    int len;
    logic [MAX_SEQ_BYTES-1:0][7:0] seq;
    bit waiting;
    bit same;
    waiting = 1'b0;
    if (func == FUNC_TICK) begin
      if (held_count == 0) return;
      if (wait_ticks <= 1) flush_held();
      else wait_ticks--;
      return;
    end
    if (held_count == 0 && b != ESC_BYTE) begin
      note_result(1'b0, b, 1'b1);
      return;
    end
    if (held_count >= MAX_SEQ_BYTES) begin
      flush_held();
      return;
    end
    held_bytes[held_count] = b;
    held_count++;
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      if (!entry_seq(e, len, seq)) continue;
      if (held_count > len) continue;
      same = 1'b1;
      for (int k = 0; k < held_count; k++)
        if (held_bytes[k] != seq[k]) same = 1'b0;
      if (!same) continue;
      if (held_count == len) begin
        held_count = 0;
        wait_ticks = '0;
        // alternates share key codes with the fixed entries in the same order
        note_result(1'b1, 8'(e % NUM_FIXED), 1'b1);
        return;
      end
      waiting = 1'b1;
    end
    if (waiting) begin
      if (held_count == 1) wait_ticks = timeout_setting;
    end else begin
      flush_held();
    end
  endfunction

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // Input driver.
  always @(negedge clk) begin : feed_proc
    key_input_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        nxt = pending_items.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.func    <= nxt.func;
        in_ch.rx_byte <= nxt.rx_byte;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Output ready, with a long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_asked != stall_served) begin
      out_ch.ready <= 1'b0;
      hold_left <= LONG_HOLD;
      stall_served <= stall_served + 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // Monitor: predict on accepted inputs, check accepted results.
  always @(posedge clk) begin : watch_proc
    key_result_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_keys.size() == 0) begin
          $display("%0t: result with none expected: is_key %0d key_value %0d last %0d",
                   $time, out_ch.is_key, out_ch.key_value, out_ch.last);
          fail_count++;
        end else begin
          want = expected_keys.pop_front();
          check_field("is_key", want.is_key, out_ch.is_key);
          check_field("key_value", want.key_value, out_ch.key_value);
          check_field("last", want.last, out_ch.last);
        end
      end
      if (in_ch.valid && in_ch.ready) predict_keys(in_ch.func, in_ch.rx_byte);
    end
  end

  function automatic void queue_byte(logic [7:0] b);
    pending_items.push_back('{FUNC_BYTE, b});
  endfunction

  function automatic void queue_ticks(int n);
    for (int i = 0; i < n; i++) pending_items.push_back('{FUNC_TICK, 8'($urandom)});
  endfunction

  function automatic logic [63:0] random_alt();
    logic [63:0] r;
    int pick;
    r = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (pick == 0) r[7:0] = 8'd0;
    else if (pick == 1) r[7:0] = 8'($urandom_range(MAX_SEQ_BYTES + 1, 255));
    else r[7:0] = 8'($urandom_range(2, MAX_SEQ_BYTES));
    if ($urandom_range(0, 9) != 0) r[15:8] = ESC_BYTE;
    if ($urandom_range(0, 1)) r[23:16] = CSI_BRACKET;
    return r;
  endfunction

  // One run: a known sequence, a cut-off one, a broken one, a raw byte or ticks.
  function automatic void queue_random_run();
    int pick;
    int len;
    int cut;
    logic [MAX_SEQ_BYTES-1:0][7:0] seq;
    bit present;
    pick = $urandom_range(0, 99);
    present = entry_seq($urandom_range(0, NUM_ENTRIES - 1), len, seq);
    if (pick < 45 && present) begin
      for (int k = 0; k < len; k++) begin
        if (k > 0 && timeout_setting >= 3 && $urandom_range(0, 7) == 0) queue_ticks(1);
        queue_byte(seq[k]);
      end
    end else if (pick < 60 && present && len > 1) begin
      cut = $urandom_range(1, len - 1);
      for (int k = 0; k < cut; k++) queue_byte(seq[k]);
      // run the wait out when it is short, otherwise break the sequence
      if (timeout_setting <= 10) queue_ticks(timeout_setting == 0 ? 1 : timeout_setting);
      else queue_byte(8'($urandom_range(0, 255)));
    end else if (pick < 75) begin
      queue_byte(ESC_BYTE);
      queue_byte($urandom_range(0, 1) ? CSI_BRACKET : 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) queue_byte(8'($urandom_range(0, 255)));
    end else if (pick < 92) begin
      queue_byte(8'($urandom_range(0, 255)));
    end else begin
      queue_ticks($urandom_range(1, 3));
    end
  endfunction

  function automatic void queue_runs(int n);
    int base;
    base = pending_items.size();
    while (pending_items.size() - base < n) queue_random_run();
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TIMEOUT) timeout_setting = val[15:0];
    else alt_setting[idx] = val;
  endtask

  task automatic load_settings(input logic [63:0] up, input logic [63:0] down,
                               input logic [63:0] left, input logic [63:0] right,
                               input logic [15:0] tmo);
    write_reg(CFG_SEQ_UP_ALT, up);
    write_reg(CFG_SEQ_DOWN_ALT, down);
    write_reg(CFG_SEQ_LEFT_ALT, left);
    write_reg(CFG_SEQ_RIGHT_ALT, right);
    write_reg(CFG_TIMEOUT, {48'd0, tmo});
  endtask

  // Wait for every item to go in and every result to come out, then let it drain.
  task automatic settle();
    while (pending_items.size() != 0 || in_ch.valid || expected_keys.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus_proc
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.func    = FUNC_BYTE;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: raw byte, idle tick, every fixed arrow, then leave ESC [ pending.
    queue_byte(8'h00);
    queue_ticks(1);
    for (int e = 0; e < NUM_FIXED; e++)
      for (int k = 0; k < FIXED_LEN; k++) queue_byte(FIXED_SEQ[e][k]);
    queue_byte(ESC_BYTE);
    queue_byte(CSI_BRACKET);
    settle();

    // New up entry ESC [ Z completes the pending prefix; zero timeout expires on
    // the first tick; a 7-byte entry with zero bytes breaks on its last byte;
    // left is too long and right has length 255, so both are absent.
    load_settings(64'h0000_0000_5A5B_1B03, 64'h017F_8000_FF00_1B07,
                  64'h4141_4141_4141_1B08, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0);
    queue_byte(8'h5A);
    queue_byte(ESC_BYTE);
    queue_ticks(1);
    queue_byte(ESC_BYTE);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_byte(8'h80);
    queue_byte(8'h7F);
    queue_byte(8'h02);
    settle();

    load_settings(random_alt(), random_alt(), random_alt(), random_alt(), 16'd3);
    queue_runs(50);
    settle();

    // Hold the output off while items keep coming so the input stalls.
    load_settings(random_alt(), random_alt(), random_alt(), random_alt(), 16'd1);
    @(posedge clk);
    stall_asked = stall_asked + 1;
    queue_runs(50);
    settle();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    load_settings(random_alt(), 64'h017F_8000_FF00_1B07, random_alt(), random_alt(), 16'd5);
    queue_runs(50);
    settle();
    src_idle_pct = 9;
    snk_idle_pct = 9;

    // A lone ESC is a whole right-key entry here.
    load_settings(64'd0, 64'd0, 64'd0, 64'h0000_0000_0000_1B01, 16'hFFFF);
    queue_runs(30);
    settle();

    load_settings(64'd0, 64'd0, 64'd0, 64'd0, 16'd2);
    queue_runs(50);
    settle();

    load_settings(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, TIMEOUT_RESET);
    queue_runs(20);
    settle();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
